// ===== sv/pgbm_pkg.sv =====
// Package with types, constants and helper functions of the partial gain beating mixer.
`timescale 1ns / 1ps
package pgbm_pkg;

    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_NOTE_ON = 2'd1,
        ACT_LOAD    = 2'd2,
        ACT_PARTIAL = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CFG_PRIMARY_LEVEL   = 2'd0,
        CFG_SECONDARY_LEVEL = 2'd1,
        CFG_HARMONIC_STRIDE = 2'd2,
        CFG_PHASE_STEP      = 2'd3
    } t_cfg_reg;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] DIVS [7]    = '{64'd182, 64'd132, 64'd90, 64'd56,
                                            64'd30, 64'd12, 64'd2};

    localparam logic signed [20:0] GAIN_MAX = 21'sd131071;
    localparam logic signed [20:0] GAIN_MIN = -21'sd131072;

    // One step of restoring division: the quotient bit on top, the new remainder below.
    function automatic logic [9:0] div_step(logic [8:0] rem, logic nb, logic [8:0] s);
        logic [9:0] t;
        t = {rem, nb};
        if (t >= {1'b0, s}) begin
            return {1'b1, 9'(t - {1'b0, s})};
        end
        return {1'b0, t[8:0]};
    endfunction

endpackage

// ===== sv/partial_gain_beating_mixer_top.sv =====
// Top level of the partial gain beating mixer: a seven stage pipeline.
`timescale 1ns / 1ps
// Usage: the input channel (i_valid, o_stall) carries one item per unstalled cycle: a tick
// that advances the beat phase, a note-on that clears it while the phase step is
// zero, a load of one secondary gain entry, or a partial. Only a partial gives a
// result on the output channel (o_valid, i_stall), with its index and the mixed
// gain in signed Q3.14, saturated.
// Configuration goes through the plain write port (i_cfg_we, i_cfg_idx,
// i_cfg_data) while no item is in flight.
// Throughput is one item per cycle while o_stall is low. The pipeline depth is set
// by the stride divider (three bits a stage), the cosine table read, the secondary
// store read and the gain multipliers.
// All stages move together: while a result waits and i_stall is high the whole
// pipeline holds and o_stall is raised, so nothing is lost or repeated.
// Reset clears the pipeline valid bits and the beat phase and loads the default
// levels and stride. The cosine table is a constant built at elaboration, and the
// secondary store holds nothing meaningful until entries are loaded.
module partial_gain_beating_mixer_top #(
    parameter int PARTIAL_COUNT   = 256,
    parameter int COS_TABLE_DEPTH = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  pgbm_pkg::t_action    i_action,
    input  logic [7:0]           i_partial_index,
    input  logic [15:0]          i_primary_gain,
    input  logic [15:0]          i_secondary_gain,
    input  logic [17:0]          i_freq_ratio,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [7:0]           o_out_index,
    output logic signed [17:0]   o_mixed_gain,
    input  logic                 i_cfg_we,
    input  pgbm_pkg::t_cfg_reg   i_cfg_idx,
    input  logic [15:0]          i_cfg_data
);
    import pgbm_pkg::*;

    localparam int AW = $clog2(PARTIAL_COUNT);
    localparam int LD = $clog2(COS_TABLE_DEPTH);

    typedef logic [15:0] t_rom [COS_TABLE_DEPTH];

    // Quarter wave entry k: Horner Taylor series in Q30, rounded to Q2.14.
    function automatic logic [15:0] quarter_cos(int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] m;
        x  = (HALF_PI_Q30 * 64'(k)) / COS_TABLE_DEPTH;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        for (int n = 0; n < 7; n++) begin
            m = ((x2 * t) >> 30) / DIVS[n];
            t = (m > Q30_ONE) ? 64'd0 : Q30_ONE - m;
        end
        return 16'((t + 64'd32768) >> 16);
    endfunction

    function automatic t_rom build_rom();
        t_rom r;
        for (int k = 0; k < COS_TABLE_DEPTH; k++) begin
            r[k] = quarter_cos(k);
        end
        return r;
    endfunction

    localparam t_rom COS_ROM = build_rom();

    logic [15:0] r_primary_level;
    logic [15:0] r_secondary_level;
    logic [8:0]  r_stride;
    logic [15:0] r_phase_step;
    logic [15:0] r_phase;

    logic [15:0] r_store [PARTIAL_COUNT];

    logic en;
    logic in_acc;

    // Stage 1
    logic        r_vld1;
    t_action     r_act1;
    logic [7:0]  r_idx1;
    logic [15:0] r_pg1, r_sg1, r_ph1;
    logic [17:0] r_ratio1;
    // Stage 2
    logic        r_vld2;
    t_action     r_act2;
    logic [7:0]  r_idx2;
    logic [15:0] r_sg2;
    logic [31:0] r_araw2;
    logic [23:0] r_f2;
    logic [8:0]  r_rem2, r_q2;
    // Stage 3
    logic        r_vld3;
    t_action     r_act3;
    logic [7:0]  r_idx3;
    logic [15:0] r_sg3;
    logic [17:0] r_a3;
    logic        r_cneg3, r_czero3;
    logic [15:0] r_cmag3;
    logic [8:0]  r_rem3, r_q3;
    // Stage 4
    logic        r_vld4, r_part4, r_mix4, r_cneg4;
    logic [7:0]  r_idx4;
    logic [17:0] r_a4;
    logic [15:0] r_cmag4, r_sec4;
    // Stage 5
    logic        r_vld5, r_part5, r_mix5, r_cneg5;
    logic [7:0]  r_idx5;
    logic [17:0] r_a5, r_b5;
    logic [15:0] r_cmag5;
    // Stage 6
    logic        r_vld6, r_part6, r_mix6, r_cneg6;
    logic [7:0]  r_idx6;
    logic [17:0] r_a6;
    logic [33:0] r_prod6;
    // Stage 7
    logic        r_vld7;
    logic [7:0]  r_idx7;
    logic [17:0] r_gain7;

    assign en      = !(r_vld7 && i_stall);
    assign o_stall = !en;
    assign in_acc  = i_valid && en;

    // Configuration and beat phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primary_level   <= 16'd16384;
            r_secondary_level <= 16'd0;
            r_stride          <= 9'd1;
            r_phase_step      <= 16'd0;
            r_phase           <= 16'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PRIMARY_LEVEL:   r_primary_level   <= i_cfg_data;
                    CFG_SECONDARY_LEVEL: r_secondary_level <= i_cfg_data;
                    CFG_HARMONIC_STRIDE: r_stride          <= i_cfg_data[8:0];
                    CFG_PHASE_STEP:      r_phase_step      <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_acc && i_action == ACT_TICK) begin
                r_phase <= r_phase + r_phase_step;
            end else if (in_acc && i_action == ACT_NOTE_ON && r_phase_step == 16'd0) begin
                r_phase <= 16'd0;
            end
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0; r_vld2 <= 1'b0; r_vld3 <= 1'b0; r_vld4 <= 1'b0;
            r_vld5 <= 1'b0; r_vld6 <= 1'b0; r_vld7 <= 1'b0;
        end else if (en) begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
            r_vld5 <= r_vld4;
            r_vld6 <= r_vld5;
            r_vld7 <= r_vld6 && r_part6;
        end
    end

    // Combinational work between stages.
    logic [8:0]  n1;
    logic [8:0]  n1_hold2, n1_hold3;
    logic [8:0]  d_rem2, d_q2, d_rem3, d_q3, d_rem4, d_q4;
    logic [9:0]  ds;
    logic [32:0] a_round;
    logic [LD+1:0] cj;
    logic [LD-1:0] cw, caddr;
    logic [8:0]  entry;
    logic        mix3;
    logic [32:0] b_full;
    logic [32:0] t_full;
    logic [18:0] term;
    logic signed [20:0] sum;

    assign n1       = 9'(r_idx1) + 9'd1;
    assign n1_hold2 = 9'(r_idx2) + 9'd1;
    assign n1_hold3 = 9'(r_idx3) + 9'd1;

    always_comb begin
        d_rem2 = 9'd0;
        d_q2   = 9'd0;
        for (int i = 8; i >= 6; i--) begin
            ds = div_step(d_rem2, n1[i], r_stride);
            d_q2[i] = ds[9];
            d_rem2  = ds[8:0];
        end
        d_rem3 = r_rem2;
        d_q3   = r_q2;
        for (int i = 5; i >= 3; i--) begin
            ds = div_step(d_rem3, n1_hold2[i], r_stride);
            d_q3[i] = ds[9];
            d_rem3  = ds[8:0];
        end
        d_rem4 = r_rem3;
        d_q4   = r_q3;
        for (int i = 2; i >= 0; i--) begin
            ds = div_step(d_rem4, n1_hold3[i], r_stride);
            d_q4[i] = ds[9];
            d_rem4  = ds[8:0];
        end
    end

    assign a_round = 33'(r_araw2) + 33'd8192;
    assign cj      = r_f2[23 -: LD + 2];
    assign cw      = cj[LD-1:0];
    assign caddr   = cj[LD] ? LD'(COS_TABLE_DEPTH - int'(cw)) : cw;

    assign entry = d_q4 - 9'd1;
    assign mix3  = (r_act3 == ACT_PARTIAL) && (r_secondary_level != 16'd0) &&
                   (r_stride != 9'd0) && (int'(r_idx3) < PARTIAL_COUNT) &&
                   (d_rem4 == 9'd0);

    assign b_full = 33'(r_sec4) * 33'(r_secondary_level) + 33'd8192;
    assign t_full = 33'(r_prod6) + 33'd8192;
    assign term   = r_mix6 ? t_full[32:14] : 19'd0;
    assign sum    = r_cneg6 ? 21'(signed'({3'b000, r_a6})) - 21'(signed'({2'b00, term}))
                            : 21'(signed'({3'b000, r_a6})) + 21'(signed'({2'b00, term}));

    // Payload registers and memories.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_act1   <= i_action;
            r_idx1   <= i_partial_index;
            r_pg1    <= i_primary_gain;
            r_sg1    <= i_secondary_gain;
            r_ratio1 <= i_freq_ratio;
            r_ph1    <= r_phase;

            r_act2   <= r_act1;
            r_idx2   <= r_idx1;
            r_sg2    <= r_sg1;
            r_araw2  <= 32'(r_pg1) * 32'(r_primary_level);
            r_f2     <= 24'(34'(r_ratio1) * 34'(r_ph1));
            r_rem2   <= d_rem2;
            r_q2     <= d_q2;

            r_act3   <= r_act2;
            r_idx3   <= r_idx2;
            r_sg3    <= r_sg2;
            r_a3     <= a_round[31:14];
            r_cneg3  <= cj[LD+1] ^ cj[LD];
            r_czero3 <= cj[LD] && (cw == '0);
            r_cmag3  <= COS_ROM[caddr];
            r_rem3   <= d_rem3;
            r_q3     <= d_q3;

            // Loads are written at the same stage where partials read, which keeps order.
            if (r_vld3 && r_act3 == ACT_LOAD && int'(r_idx3) < PARTIAL_COUNT) begin
                r_store[AW'(r_idx3)] <= r_sg3;
            end
            r_sec4   <= r_store[AW'(entry)];
            r_part4  <= r_act3 == ACT_PARTIAL;
            r_mix4   <= mix3;
            r_cneg4  <= r_cneg3;
            r_idx4   <= r_idx3;
            r_a4     <= r_a3;
            r_cmag4  <= r_czero3 ? 16'd0 : r_cmag3;

            r_part5  <= r_part4;
            r_mix5   <= r_mix4;
            r_cneg5  <= r_cneg4;
            r_idx5   <= r_idx4;
            r_a5     <= r_a4;
            r_b5     <= b_full[31:14];
            r_cmag5  <= r_cmag4;

            r_part6  <= r_part5;
            r_mix6   <= r_mix5;
            r_cneg6  <= r_cneg5;
            r_idx6   <= r_idx5;
            r_a6     <= r_a5;
            r_prod6  <= 34'(r_b5) * 34'(r_cmag5);

            r_idx7   <= r_idx6;
            if (sum > GAIN_MAX) begin
                r_gain7 <= 18'(GAIN_MAX);
            end else if (sum < GAIN_MIN) begin
                r_gain7 <= 18'(GAIN_MIN);
            end else begin
                r_gain7 <= 18'(sum);
            end
        end
    end

    assign o_valid      = r_vld7;
    assign o_out_index  = r_idx7;
    assign o_mixed_gain = signed'(r_gain7);

    a_note_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_action == ACT_NOTE_ON && r_phase_step == 16'd0 && !i_cfg_we
        |=> r_phase == 16'd0)
        else $error("phase not cleared by note-on");

    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_action == ACT_TICK && !i_cfg_we
        |=> r_phase == $past(r_phase + r_phase_step))
        else $error("phase did not advance by one step");

    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (i_stall && o_valid))
        else $error("input stalled without a waiting result");

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the partial gain beating mixer.
`timescale 1ns / 1ps
module tb;
    import pgbm_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 12;
    localparam int ROM_DEPTH    = 1024;

    typedef enum logic { ROW_ITEM, ROW_CFG } t_row_kind;

    typedef struct {
        t_row_kind          kind;
        t_action            act;
        logic [7:0]         idx;
        logic [15:0]        pg;
        logic [15:0]        sg;
        logic [17:0]        ratio;
        bit                 has_fix;
        logic signed [17:0] fix;
        t_cfg_reg           reg_sel;
        logic [15:0]        reg_val;
    } t_row;

    typedef struct {
        logic [7:0]         idx;
        logic signed [17:0] gain;
    } t_gain_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    t_action            i_action;
    logic [7:0]         i_partial_index;
    logic [15:0]        i_primary_gain;
    logic [15:0]        i_secondary_gain;
    logic [17:0]        i_freq_ratio;
    logic               o_valid;
    logic               i_stall;
    logic [7:0]         o_out_index;
    logic signed [17:0] o_mixed_gain;
    logic               i_cfg_we;
    t_cfg_reg           i_cfg_idx;
    logic [15:0]        i_cfg_data;

    partial_gain_beating_mixer_top dut (.*);

    // Predictor state.
    logic [15:0] lvl_primary;
    logic [15:0] lvl_secondary;
    logic [8:0]  stride;
    logic [15:0] phase_inc;
    logic [15:0] phase;
    logic [15:0] gain_store [256];
    logic [15:0] cos_quarter [ROM_DEPTH];

    t_gain_result pending_gains[$];
    int           errors;
    int           cycles;
    int           send_pct;
    int           stall_pct;
    int           hold_cnt;
    bit           hold_req;

    function automatic logic [15:0] quarter_cos_entry(int unsigned k);
        longint unsigned divisor [7];
        longint unsigned x, x2, t, m;
        divisor = '{182, 132, 90, 56, 30, 12, 2};
        x  = (64'd1686629713 * k) / ROM_DEPTH;
        x2 = (x * x) >> 30;
        t  = 64'd1 << 30;
        for (int n = 0; n < 7; n++) begin
            m = ((x2 * t) >> 30) / divisor[n];
            t = (m > (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - m;
        end
        return 16'((t + 32768) >> 16);
    endfunction

    function automatic longint cos_at(int unsigned w);
        return (w >= ROM_DEPTH) ? 0 : longint'(cos_quarter[w]);
    endfunction

    function automatic logic signed [17:0] mixed_gain_of(logic [7:0] idx, logic [15:0] pg,
                                                         logic [17:0] ratio);
        longint      sum, b, c, mag;
        int unsigned slot, w;
        logic [23:0] frac;
        logic [11:0] j;
        sum = (longint'(pg) * longint'(lvl_primary) + 8192) >>> 14;
        if (lvl_secondary != 0 && stride != 0 && ((int'(idx) + 1) % int'(stride)) == 0) begin
            slot = (int'(idx) + 1) / int'(stride) - 1;
            b    = (longint'(gain_store[slot]) * longint'(lvl_secondary) + 8192) >>> 14;
            frac = 24'(longint'(ratio) * longint'(phase));
            j    = frac[23:12];
            w    = j[9:0];
            case (j[11:10])
                2'd0: c = cos_at(w);
                2'd1: c = -cos_at(ROM_DEPTH - w);
                2'd2: c = -cos_at(w);
                default: c = cos_at(ROM_DEPTH - w);
            endcase
            mag = (b * (c < 0 ? -c : c) + 8192) >>> 14;
            sum = (c < 0) ? sum - mag : sum + mag;
        end
        if (sum > 131071) sum = 131071;
        if (sum < -131072) sum = -131072;
        return 18'(sum);
    endfunction

    // Updates the predictor with one accepted item and queues the result of a partial.
    function automatic void absorb_item(t_row r);
        t_gain_result res;
        case (r.act)
            ACT_TICK: phase = phase + phase_inc;
            ACT_NOTE_ON: if (phase_inc == 0) phase = '0;
            ACT_LOAD: gain_store[r.idx] = r.sg;
            ACT_PARTIAL: begin
                res.idx  = r.idx;
                res.gain = r.has_fix ? r.fix : mixed_gain_of(r.idx, r.pg, r.ratio);
                pending_gains.push_back(res);
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("ERROR @%0t %s: got %0d, want %0d", $realtime, what, got, want);
        errors++;
    endtask

    initial begin
        i_clk = 0;
        forever begin
            #4 i_clk = ~i_clk;
            if (i_clk) begin
                cycles++;
                if (cycles > LIMIT_CYCLES) begin
                    $display("SCOREBOARD MISMATCH");
                    $finish;
                end
            end
        end
    end

    // Result side: stall pattern, with a long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_cnt = 300;
            hold_req = 0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Outputs and i_stall are stable at the falling edge, so this is what the next
    // rising edge accepts.
    always @(negedge i_clk) begin
        t_gain_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_gains.size() == 0) begin
                report_mismatch("unexpected result, index", o_out_index, -1);
            end else begin
                want = pending_gains.pop_front();
                if (o_out_index !== want.idx)
                    report_mismatch("out_index", o_out_index, want.idx);
                if (o_mixed_gain !== want.gain)
                    report_mismatch("mixed_gain", o_mixed_gain, want.gain);
            end
        end
    end

    task automatic send_item(t_row r);
        bit taken;
        while ($urandom_range(0, 99) < send_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_action         <= r.act;
        i_partial_index  <= r.idx;
        i_primary_gain   <= r.pg;
        i_secondary_gain <= r.sg;
        i_freq_ratio     <= r.ratio;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
        absorb_item(r);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_gains.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg sel, logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= sel;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (sel)
            CFG_PRIMARY_LEVEL:   lvl_primary   = val;
            CFG_SECONDARY_LEVEL: lvl_secondary = val;
            CFG_HARMONIC_STRIDE: stride        = val[8:0];
            CFG_PHASE_STEP:      phase_inc     = val;
            default: ;
        endcase
    endtask

    function automatic t_row item_row(t_action act, logic [7:0] idx, logic [15:0] pg,
                                      logic [15:0] sg, logic [17:0] ratio);
        t_row r;
        r.kind = ROW_ITEM; r.act = act; r.idx = idx; r.pg = pg; r.sg = sg; r.ratio = ratio;
        r.has_fix = 0; r.fix = '0; r.reg_sel = CFG_PRIMARY_LEVEL; r.reg_val = '0;
        return r;
    endfunction

    function automatic t_row fixed_row(logic [7:0] idx, logic [15:0] pg, logic [17:0] ratio,
                                       logic signed [17:0] gain);
        t_row r;
        r = item_row(ACT_PARTIAL, idx, pg, 16'h0, ratio);
        r.has_fix = 1;
        r.fix     = gain;
        return r;
    endfunction

    function automatic t_row cfg_row(t_cfg_reg sel, logic [15:0] val);
        t_row r;
        r = item_row(ACT_TICK, 8'h0, 16'h0, 16'h0, 18'h0);
        r.kind    = ROW_CFG;
        r.reg_sel = sel;
        r.reg_val = val;
        return r;
    endfunction

    function automatic t_row random_row();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        return item_row(pick < 12 ? ACT_TICK : pick < 17 ? ACT_NOTE_ON :
                        pick < 32 ? ACT_LOAD : ACT_PARTIAL,
                        8'($urandom), 16'($urandom), 16'($urandom), 18'($urandom));
    endfunction

    task automatic random_config();
        int unsigned pick;
        wait_idle();
        write_reg(CFG_PRIMARY_LEVEL, 16'($urandom));
        write_reg(CFG_SECONDARY_LEVEL, ($urandom_range(0, 7) == 0) ? 16'h0 : 16'($urandom));
        pick = $urandom_range(0, 9);
        write_reg(CFG_HARMONIC_STRIDE, pick < 6 ? 16'($urandom_range(1, 4)) :
                  pick < 8 ? 16'($urandom_range(1, 256)) : pick == 8 ? 16'd256 : 16'd0);
        write_reg(CFG_PHASE_STEP, ($urandom_range(0, 5) == 0) ? 16'h0 : 16'($urandom));
    endtask

    t_row directed [$];

    initial begin
        errors = 0; cycles = 0; send_pct = 0; stall_pct = 0; hold_cnt = 0; hold_req = 0;
        i_rst_n = 0; i_valid = 0; i_action = ACT_TICK; i_partial_index = '0;
        i_primary_gain = '0; i_secondary_gain = '0; i_freq_ratio = '0;
        i_stall = 0; i_cfg_we = 0; i_cfg_idx = CFG_PRIMARY_LEVEL; i_cfg_data = '0;
        lvl_primary = 16384; lvl_secondary = 0; stride = 1; phase_inc = 0; phase = 0;
        for (int k = 0; k < ROM_DEPTH; k++) cos_quarter[k] = quarter_cos_entry(k);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the whole secondary store so no partial ever reads an empty entry.
        for (int k = 0; k < 256; k++)
            send_item(item_row(ACT_LOAD, 8'(k), 16'h0, 16'($urandom), 18'h0));

        directed = '{
            fixed_row(8'd0, 16'h0000, 18'h0, 18'sd0),
            fixed_row(8'd255, 16'hFFFF, 18'h3FFFF, 18'sd65535),
            fixed_row(8'd7, 16'd16384, 18'h0, 18'sd16384),
            item_row(ACT_TICK, 8'd0, 16'h0, 16'h0, 18'h0),
            item_row(ACT_NOTE_ON, 8'd0, 16'h0, 16'h0, 18'h0),
            cfg_row(CFG_PRIMARY_LEVEL, 16'hFFFF),
            fixed_row(8'd3, 16'hFFFF, 18'h0, 18'sd131071),
            cfg_row(CFG_PRIMARY_LEVEL, 16'h0000),
            cfg_row(CFG_SECONDARY_LEVEL, 16'hFFFF),
            cfg_row(CFG_PHASE_STEP, 16'h8000),
            item_row(ACT_LOAD, 8'd0, 16'h0, 16'hFFFF, 18'h0),
            item_row(ACT_TICK, 8'd0, 16'h0, 16'h0, 18'h0),
            // Half a turn: cosine is minus one, so the sum clips low.
            fixed_row(8'd0, 16'h0, 18'd256, -18'sd131072),
            // A note-on with a nonzero step leaves the phase alone.
            item_row(ACT_NOTE_ON, 8'd0, 16'h0, 16'h0, 18'h0),
            fixed_row(8'd0, 16'h0, 18'd256, -18'sd131072),
            cfg_row(CFG_HARMONIC_STRIDE, 16'd0),
            fixed_row(8'd0, 16'hFFFF, 18'd256, 18'sd0),
            cfg_row(CFG_HARMONIC_STRIDE, 16'd256),
            cfg_row(CFG_PRIMARY_LEVEL, 16'd16384),
            item_row(ACT_PARTIAL, 8'd255, 16'hFFFF, 16'h0, 18'h3FFFF),
            cfg_row(CFG_PHASE_STEP, 16'h0),
            item_row(ACT_NOTE_ON, 8'd0, 16'h0, 16'h0, 18'h0),
            item_row(ACT_PARTIAL, 8'd255, 16'h1234, 16'h0, 18'h15555)
        };
        foreach (directed[n]) begin
            if (directed[n].kind == ROW_CFG) begin
                wait_idle();
                write_reg(directed[n].reg_sel, directed[n].reg_val);
            end else begin
                send_item(directed[n]);
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            random_config();
            send_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 50 : 36) : 0;
            stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 50 : 36) : 0;
            for (int n = 0; n < 105; n++) begin
                if (ph == 0 && n == 40) hold_req = 1;
                if (n == 55) begin
                    random_config();
                end
                send_item(random_row());
            end
        end
        send_pct = 0;
        stall_pct = 0;
        wait_idle();

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ===== files.f =====
sv/pgbm_pkg.sv
sv/partial_gain_beating_mixer_top.sv
bench/tb.sv
